@@ hdl/srfc_pkg.sv @@
`timescale 1ns / 1ps

package srfc_pkg;

	localparam int unsigned SHORT_LIMIT = 5;
	localparam int unsigned LEN_POS     = 3;
	localparam int unsigned PAYLOAD_POS = 4;

	localparam logic [15:0] RESPONSE_HEADER_RESET  = 16'h1C05;
	localparam logic [7:0]  EXPECTED_COMMAND_RESET = 8'h00;

	typedef enum logic [0:0] {
		REG_RESPONSE_HEADER  = 1'b0,
		REG_EXPECTED_COMMAND = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_HEADER   = 3'd2,
		ST_COMMAND  = 3'd3,
		ST_CHECKSUM = 3'd4,
		ST_TRUNC    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		CV_NONE     = 2'd0,
		CV_MATCH    = 2'd1,
		CV_MISMATCH = 2'd2
	} verdict_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       chunk_end;
	} in_item_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] payload_length;
	} out_item_t;

endpackage

@@ hdl/servo_response_frame_checker.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  srfc_pkg::in_item_t (rx_byte, chunk_end)
// out       output     out_valid / out_stall srfc_pkg::out_item_t (status, payload_length)
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data (16 bit)
//
// One byte is accepted per cycle while in_stall is low; a byte is held in the input register
// and its status, if it ends a chunk, is then registered in the output register.
// The asynchronous reset clears the frame state and loads the register reset values.
// Input is stalled only while a chunk end waits in the input register behind a stalled result.

module servo_response_frame_checker #(
	parameter int MAX_FRAME_BYTES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  srfc_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output srfc_pkg::out_item_t  out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  srfc_pkg::reg_index_t cfg_index,
	input  logic [15:0]          cfg_data
);
	import srfc_pkg::*;

	localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);

	logic [15:0] response_header_q;
	logic [7:0]  expected_command_q;

	logic       valid_s1;
	in_item_t   item_s1;
	logic       out_valid_q;
	out_item_t  out_q;

	logic [IDX_W-1:0] byte_index_q;
	logic [7:0]       running_sum_q;
	logic [7:0]       header_low_q;
	logic             header_bad_q;
	logic             command_bad_q;
	logic [7:0]       declared_length_q;
	verdict_t         checksum_verdict_q;

	logic [IDX_W-1:0] byte_index_d;
	logic [7:0]       running_sum_d;
	logic [7:0]       header_low_d;
	logic             header_bad_d;
	logic             command_bad_d;
	logic [7:0]       declared_length_d;
	verdict_t         checksum_verdict_d;
	status_t          status_d;
	logic [7:0]       payload_length_d;

	logic out_free;
	logic s1_go;
	logic s1_load;
	logic take;
	logic [8:0] check_pos;

	assign out_free  = !out_valid_q || !out_stall;
	assign s1_go     = valid_s1 && (!item_s1.chunk_end || out_free);
	assign in_stall  = valid_s1 && !s1_go;
	assign s1_load   = !valid_s1 || s1_go;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign take      = byte_index_q < IDX_W'(MAX_FRAME_BYTES);
	assign check_pos = 9'(PAYLOAD_POS) + {1'b0, declared_length_q};

	always_comb begin
		byte_index_d       = byte_index_q;
		running_sum_d      = running_sum_q;
		header_low_d       = header_low_q;
		header_bad_d       = header_bad_q;
		command_bad_d      = command_bad_q;
		declared_length_d  = declared_length_q;
		checksum_verdict_d = checksum_verdict_q;
		if (take) begin
			if (byte_index_q == IDX_W'(0)) begin
				header_low_d = item_s1.rx_byte;
			end else if (byte_index_q == IDX_W'(1)) begin
				header_bad_d = {item_s1.rx_byte, header_low_q} != response_header_q;
			end else if (byte_index_q == IDX_W'(2)) begin
				command_bad_d = item_s1.rx_byte != expected_command_q;
			end else if (byte_index_q == IDX_W'(LEN_POS)) begin
				declared_length_d = item_s1.rx_byte;
			end
			if (checksum_verdict_q == CV_NONE) begin
				if (byte_index_q >= IDX_W'(PAYLOAD_POS)
						&& 9'(byte_index_q) == check_pos) begin
					checksum_verdict_d = (item_s1.rx_byte == running_sum_q) ?
						CV_MATCH : CV_MISMATCH;
				end else begin
					running_sum_d = running_sum_q + item_s1.rx_byte;
				end
			end
			byte_index_d = byte_index_q + IDX_W'(1);
		end
	end

	always_comb begin
		if (byte_index_d <= IDX_W'(SHORT_LIMIT)) begin
			status_d = ST_SHORT;
		end else if (header_bad_d) begin
			status_d = ST_HEADER;
		end else if (command_bad_d) begin
			status_d = ST_COMMAND;
		end else if (checksum_verdict_d == CV_NONE) begin
			status_d = ST_TRUNC;
		end else if (checksum_verdict_d == CV_MISMATCH) begin
			status_d = ST_CHECKSUM;
		end else begin
			status_d = ST_OK;
		end
		payload_length_d = (byte_index_d > IDX_W'(LEN_POS)) ? declared_length_d : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			response_header_q  <= RESPONSE_HEADER_RESET;
			expected_command_q <= EXPECTED_COMMAND_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RESPONSE_HEADER:  response_header_q  <= cfg_data;
				REG_EXPECTED_COMMAND: expected_command_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && in_valid) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && item_s1.chunk_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && item_s1.chunk_end) begin
			out_q.status         <= status_d;
			out_q.payload_length <= payload_length_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q       <= '0;
			running_sum_q      <= '0;
			header_low_q       <= '0;
			header_bad_q       <= 1'b0;
			command_bad_q      <= 1'b0;
			declared_length_q  <= '0;
			checksum_verdict_q <= CV_NONE;
		end else if (s1_go) begin
			if (item_s1.chunk_end) begin
				byte_index_q       <= '0;
				running_sum_q      <= '0;
				header_low_q       <= '0;
				header_bad_q       <= 1'b0;
				command_bad_q      <= 1'b0;
				declared_length_q  <= '0;
				checksum_verdict_q <= CV_NONE;
			end else begin
				byte_index_q       <= byte_index_d;
				running_sum_q      <= running_sum_d;
				header_low_q       <= header_low_d;
				header_bad_q       <= header_bad_d;
				command_bad_q      <= command_bad_d;
				declared_length_q  <= declared_length_d;
				checksum_verdict_q <= checksum_verdict_d;
			end
		end
	end

	// A stall on the input side can only come from a finished chunk blocked at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && item_s1.chunk_end && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

	assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && item_s1.chunk_end |=> byte_index_q == '0 && checksum_verdict_q == CV_NONE
			&& out_valid_q)
		else $error("frame state not cleared after chunk end");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.status <= ST_TRUNC)
		else $error("status code out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		byte_index_q <= IDX_W'(MAX_FRAME_BYTES))
		else $error("byte index past frame limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		checksum_verdict_q != CV_NONE |-> byte_index_q > IDX_W'(PAYLOAD_POS))
		else $error("checksum verdict before payload position");

endmodule

@@ sim/servo_response_frame_checker_tb.sv @@
`timescale 1ns / 1ps

module servo_response_frame_checker_tb;
	import srfc_pkg::*;

	localparam int FRAME_CAP = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BYTES = 320;
	localparam int PHASES = 6;

	typedef struct {
		logic [7:0] rx;
		logic       last;
		bit         typed;
		status_t    st;
		logic [7:0] plen;
	} frame_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_item_t   in_item;
	logic       out_valid;
	logic       out_stall;
	out_item_t  out_item;
	logic       cfg_valid;
	logic       cfg_ready;
	reg_index_t cfg_index;
	logic [15:0] cfg_data;

	logic [15:0] cur_header;
	logic [7:0]  cur_command;
	int unsigned fr_count;
	logic [7:0]  fr_sum;
	logic [7:0]  fr_hdr_low;
	bit          fr_hdr_bad;
	bit          fr_cmd_bad;
	logic [7:0]  fr_len;
	verdict_t    fr_verdict;

	out_item_t   awaited_verdicts[$];
	logic [7:0]  chunk_bytes[$];
	int          mismatches = 0;
	int          cycle_count = 0;
	int          burst_left = 0;
	int          stall_left = 0;
	int          stall_mode = 0;

	frame_row_t directed_rows [25] = '{
		'{8'hFF, 1'b1, 1'b1, ST_SHORT, 8'h00},
		'{8'h05, 1'b0, 1'b0, ST_OK, 8'h00},
		'{8'h1C, 1'b0, 1'b0, ST_OK, 8'h00},
		'{8'h00, 1'b0, 1'b0, ST_OK, 8'h00},
		'{8'h00, 1'b0, 1'b0, ST_OK, 8'h00},
		'{8'h21, 1'b0, 1'b0, ST_OK, 8'h00},
		'{8'hAA, 1'b1, 1'b1, ST_OK, 8'h00},
		'{8'h05, 1'b0, 1'b0, ST_OK, 8'h00},
		'{8'h1D, 1'b0, 1'b0, ST_OK, 8'h00},
		'{8'h00, 1'b0, 1'b0, ST_OK, 8'h00},
		'{8'h00, 1'b0, 1'b0, ST_OK, 8'h00},
		'{8'h22, 1'b0, 1'b0, ST_OK, 8'h00},
		'{8'h00, 1'b1, 1'b1, ST_HEADER, 8'h00},
		'{8'h05, 1'b0, 1'b0, ST_OK, 8'h00},
		'{8'h1C, 1'b0, 1'b0, ST_OK, 8'h00},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 8'h00},
		'{8'h00, 1'b0, 1'b0, ST_OK, 8'h00},
		'{8'h20, 1'b0, 1'b0, ST_OK, 8'h00},
		'{8'h00, 1'b1, 1'b1, ST_COMMAND, 8'h00},
		'{8'h05, 1'b0, 1'b0, ST_OK, 8'h00},
		'{8'h1C, 1'b0, 1'b0, ST_OK, 8'h00},
		'{8'h00, 1'b0, 1'b0, ST_OK, 8'h00},
		'{8'h01, 1'b0, 1'b0, ST_OK, 8'h00},
		'{8'h80, 1'b0, 1'b0, ST_OK, 8'h00},
		'{8'h00, 1'b1, 1'b1, ST_CHECKSUM, 8'h01}
	};

	servo_response_frame_checker #(
		.MAX_FRAME_BYTES(FRAME_CAP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[servo_response_frame_checker] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= (stall_left % 8 < 5);
		endcase
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	function automatic void clear_frame_state();
		fr_count = 0;
		fr_sum = 8'h00;
		fr_hdr_low = 8'h00;
		fr_hdr_bad = 1'b0;
		fr_cmd_bad = 1'b0;
		fr_len = 8'h00;
		fr_verdict = CV_NONE;
	endfunction

	function automatic void advance_frame(input logic [7:0] b, input logic last,
			output bit produced, output out_item_t verdict);
		int unsigned pos;
		produced = 1'b0;
		verdict = '0;
		if (fr_count < FRAME_CAP) begin
			pos = fr_count;
			if (pos == 0)
				fr_hdr_low = b;
			else if (pos == 1)
				fr_hdr_bad = ({b, fr_hdr_low} != cur_header);
			else if (pos == 2)
				fr_cmd_bad = (b != cur_command);
			else if (pos == LEN_POS)
				fr_len = b;
			if (fr_verdict == CV_NONE) begin
				if (pos >= PAYLOAD_POS && pos == PAYLOAD_POS + fr_len)
					fr_verdict = (b == fr_sum) ? CV_MATCH : CV_MISMATCH;
				else
					fr_sum = fr_sum + b;
			end
			fr_count++;
		end
		if (last) begin
			produced = 1'b1;
			if (fr_count <= SHORT_LIMIT)
				verdict.status = ST_SHORT;
			else if (fr_hdr_bad)
				verdict.status = ST_HEADER;
			else if (fr_cmd_bad)
				verdict.status = ST_COMMAND;
			else if (fr_verdict == CV_NONE)
				verdict.status = ST_TRUNC;
			else if (fr_verdict == CV_MISMATCH)
				verdict.status = ST_CHECKSUM;
			else
				verdict.status = ST_OK;
			verdict.payload_length = (fr_count > LEN_POS) ? fr_len : 8'h00;
			clear_frame_state();
		end
	endfunction

	// Mostly well-formed frames for the current settings, with some corrupted
	// fields, oversized or cut-off lengths and plain noise mixed in.
	function automatic void build_chunk();
		int kind;
		int len;
		int body;
		int trail;
		logic [15:0] hdr;
		logic [7:0] cmd;
		logic [7:0] sum;
		chunk_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			repeat ($urandom_range(1, 12)) chunk_bytes.push_back(8'($urandom));
			return;
		end
		hdr = cur_header;
		if ($urandom_range(0, 9) == 0)
			hdr = hdr ^ (16'h0001 << $urandom_range(0, 15));
		cmd = cur_command;
		if ($urandom_range(0, 9) == 0)
			cmd = 8'($urandom);
		if (kind < 80)
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 58) : $urandom_range(0, 8);
		else
			len = $urandom_range(0, 255);
		body = (kind < 80) ? len : $urandom_range(0, (len < 75) ? len : 75);
		chunk_bytes.push_back(hdr[7:0]);
		chunk_bytes.push_back(hdr[15:8]);
		chunk_bytes.push_back(cmd);
		chunk_bytes.push_back(8'(len));
		repeat (body) chunk_bytes.push_back(8'($urandom));
		sum = 8'h00;
		foreach (chunk_bytes[k])
			sum = sum + chunk_bytes[k];
		if (body == len) begin
			if ($urandom_range(0, 9) == 0)
				sum = sum ^ 8'($urandom_range(1, 255));
			chunk_bytes.push_back(sum);
			trail = ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(0, 3);
			repeat (trail) chunk_bytes.push_back(8'($urandom));
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
			input out_item_t typed_result);
		int gap;
		bit produced;
		out_item_t pred;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_item <= '{rx_byte: b, chunk_end: last};
		do @(posedge clk); while (in_stall);
		advance_frame(b, last, produced, pred);
		if (produced)
			awaited_verdicts.push_back(typed ? typed_result : pred);
	endtask

	task automatic write_register(input reg_index_t idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_RESPONSE_HEADER)
			cur_header = value;
		else
			cur_command = value[7:0];
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (awaited_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_verdicts.size() == 0) begin
				report_mismatch($sformatf("unexpected result status %0d length %0d",
					out_item.status, out_item.payload_length));
			end else begin
				want = awaited_verdicts.pop_front();
				if (out_item.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						out_item.status, want.status));
				if (out_item.payload_length !== want.payload_length)
					report_mismatch($sformatf("payload_length %0d, expected %0d",
						out_item.payload_length, want.payload_length));
			end
		end
	end

	initial begin
		int sent;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_RESPONSE_HEADER;
		cfg_data <= 16'h0000;
		cur_header = RESPONSE_HEADER_RESET;
		cur_command = EXPECTED_COMMAND_RESET;
		clear_frame_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			send_byte(directed_rows[r].rx, directed_rows[r].last, directed_rows[r].typed,
				'{status: directed_rows[r].st, payload_length: directed_rows[r].plen});

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				drain_results();
				case (phase)
					1: begin
						write_register(REG_RESPONSE_HEADER, 16'h0000);
						write_register(REG_EXPECTED_COMMAND, 16'h0000);
					end
					2: begin
						write_register(REG_RESPONSE_HEADER, 16'hFFFF);
						write_register(REG_EXPECTED_COMMAND, 16'h00FF);
					end
					default: begin
						write_register(REG_EXPECTED_COMMAND, 16'($urandom));
						write_register(REG_RESPONSE_HEADER, 16'($urandom));
					end
				endcase
				cfg_valid <= 1'b0;
			end
			sent = 0;
			while (sent < PHASE_BYTES) begin
				build_chunk();
				foreach (chunk_bytes[k])
					send_byte(chunk_bytes[k], k == chunk_bytes.size() - 1, 1'b0, '0);
				sent += chunk_bytes.size();
			end
			// Leave a frame open so the next settings apply to its header check.
			if (phase % 2 == 1)
				send_byte(cur_header[7:0], 1'b0, 1'b0, '0);
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (awaited_verdicts.size() != 0)
			report_mismatch("results still outstanding at end of run");
		if (mismatches == 0) begin
			$display("[servo_response_frame_checker] OK");
		end else begin
			$display("[servo_response_frame_checker] ERROR");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hdl/srfc_pkg.sv
hdl/servo_response_frame_checker.sv
sim/servo_response_frame_checker_tb.sv
